// ===== rtl/phcq_pkg.sv =====
// Shared types, codes and the scancode table of the PS/2 host command queue.
package phcq_pkg;

   localparam logic [1:0] KIND_SEND   = 2'd0;
   localparam logic [1:0] KIND_KEY    = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [7:0] BYTE_ACK    = 8'hFA;
   localparam logic [7:0] BYTE_RESEND = 8'hFE;

   localparam int unsigned MAP_SIZE = 81;

   // Set-1 scancode to key code; zero marks an unmapped code.
   localparam logic [7:0] KEY_TABLE [MAP_SIZE] = '{
      8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h80, 8'h00, 8'h00, 8'h81, 8'h00, 8'h82, 8'h00, 8'h00,
      8'h83
   };

   // One unit of work for the output side: one or two result bytes.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_hi;
      logic [7:0] byte_lo;
      logic       two;
   } job_type;

   function automatic logic [7:0] key_lookup(input logic [7:0] code);
      logic [7:0] key;
      key = 8'h00;
      if (code < 8'(MAP_SIZE)) begin
         key = KEY_TABLE[code[6:0]];
      end
      return key;
   endfunction

   function automatic job_type make_send(input logic [15:0] word);
      job_type j;
      j.kind    = KIND_SEND;
      j.byte_hi = word[15:8];
      j.byte_lo = word[7:0];
      j.two     = (word[15:8] != 8'h00);
      return j;
   endfunction

   function automatic job_type make_single(input logic [1:0] kind, input logic [7:0] value);
      job_type j;
      j.kind    = kind;
      j.byte_hi = 8'h00;
      j.byte_lo = value;
      j.two     = 1'b0;
      return j;
   endfunction

endpackage

// ===== rtl/phcq_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
interface phcq_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] command_word;
   logic [7:0]  rx_byte;
   logic        from_port;

   modport source (output valid, cmd, command_word, rx_byte, from_port, input ready);
   modport sink   (input valid, cmd, command_word, rx_byte, from_port, output ready);
endinterface

interface phcq_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;
   logic       last;

   modport source (output valid, kind, value, last, input ready);
   modport sink   (input valid, kind, value, last, output ready);
endinterface

// ===== rtl/phcq_front.sv =====
// Front end: accepts requests, keeps the command queue and makes at most one job per request.
module phcq_front #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   phcq_req_if.sink          req,
   input  logic              jobq_full,
   output logic              push,
   output phcq_pkg::job_type push_job
);

   localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SUM_W = IDX_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FETCH = 2'b10
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      store [QUEUE_DEPTH];
   logic [15:0]      rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] slot;
   logic [IDX_W-1:0] head_next;
   logic [SUM_W-1:0] slot_sum;
   logic             wr_en;
   logic             accept;
   logic             queue_full;
   logic             queue_empty;
   logic [7:0]       key;

   assign req.ready   = (state_ff == ST_IDLE) && !jobq_full;
   assign accept      = req.valid && req.ready;
   assign queue_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign key         = phcq_pkg::key_lookup(req.rx_byte);

   assign slot_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign slot      = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      IDX_W'(slot_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(slot_sum);
   assign head_next = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      rd_addr  = head_ff;
      push     = 1'b0;
      push_job = phcq_pkg::make_send(rd_data_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req.cmd) begin
                  if (queue_full) begin
                     push     = 1'b1;
                     push_job = phcq_pkg::make_single(phcq_pkg::KIND_REJECT, 8'h00);
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     if (queue_empty) begin
                        push     = 1'b1;
                        push_job = phcq_pkg::make_send(req.command_word);
                     end
                  end
               end else if (!req.from_port) begin
                  if (!queue_empty) begin
                     if (req.rx_byte == phcq_pkg::BYTE_ACK) begin
                        head_in  = head_next;
                        count_in = count_ff - 1'b1;
                        rd_addr  = head_next;
                        if (count_ff != CNT_W'(1)) begin
                           state_in = ST_FETCH;
                        end
                     end else if (req.rx_byte == phcq_pkg::BYTE_RESEND) begin
                        state_in = ST_FETCH;
                     end
                  end else if (key != 8'h00) begin
                     push     = 1'b1;
                     push_job = phcq_pkg::make_single(phcq_pkg::KIND_KEY, key);
                  end
               end
            end
         end
         ST_FETCH: begin
            // The head command read in the accept cycle is now on rd_data_ff.
            push     = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[slot] <= req.command_word;
      end
      rd_data_ff <= store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("command count exceeds queue depth");
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= IDX_W'(QUEUE_DEPTH - 1))
      else $error("head index out of range");
`endif

endmodule

// ===== rtl/phcq_jobq.sv =====
// Two-entry job queue between the front end and the output sequencer.
module phcq_jobq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  phcq_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              valid,
   output phcq_pkg::job_type head_job
);

   phcq_pkg::job_type entries [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign head_job = entries[rd_ptr_ff];
   assign do_pop   = pop && valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job pushed into a full job queue");
`endif

endmodule

// ===== rtl/phcq_back.sv =====
// Output sequencer: expands each job into one or two response transactions.
module phcq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  phcq_pkg::job_type job,
   output logic              pop,
   phcq_rsp_if.source        rsp
);

   phcq_pkg::job_type job_ff;
   logic       have_job_ff;
   logic       phase_ff;
   logic       rsp_valid_ff;
   logic [1:0] rsp_kind_ff;
   logic [7:0] rsp_value_ff;
   logic       rsp_last_ff;
   logic       out_free;
   logic       emit;
   logic       first_of_two;

   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign emit         = have_job_ff && out_free;
   assign first_of_two = job_ff.two && !phase_ff;
   assign pop          = !have_job_ff && job_valid;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.kind  = rsp_kind_ff;
   assign rsp.value = rsp_value_ff;
   assign rsp.last  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= job;
      end
      if (emit) begin
         rsp_kind_ff  <= job_ff.kind;
         rsp_value_ff <= first_of_two ? job_ff.byte_hi : job_ff.byte_lo;
         rsp_last_ff  <= !first_of_two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_job_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            if (first_of_two) begin
               phase_ff <= 1'b1;
            end else begin
               have_job_ff <= 1'b0;
            end
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop) begin
            have_job_ff <= 1'b1;
            phase_ff    <= 1'b0;
         end
      end
   end

`ifndef ASSERT_OFF
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp.ready && !rsp_last_ff |=> rsp_valid_ff)
      else $error("second byte of a command did not follow the first");
`endif

endmodule

// ===== rtl/ps2_host_command_queue_top.sv =====
// Top level of the PS/2 host command queue: front end, job queue and output sequencer.
// A result passes through a job queue entry, the sequencer's job register and the response
// register. An ACK or a resend first reads the head command from the command store. Reset is
// synchronous and clears pointers and handshake state, not the store. One request is taken per
// cycle while the front end is idle and the job queue has room; an ACK with commands left or a
// resend blocks requests during the head read; the sequencer pops a job only when idle.
module ps2_host_command_queue_top #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   phcq_req_if.sink   req_chan,
   phcq_rsp_if.source rsp_chan
);

   // Jobs travel from the front end to the output sequencer through a
   // two-entry queue. The front end only accepts a request transaction when
   // the queue has a free slot, so a job produced in the next cycle by a store
   // read always finds room.
   logic              push;
   phcq_pkg::job_type push_job;
   logic              jobq_full;
   logic              jobq_valid;
   phcq_pkg::job_type jobq_head;
   logic              pop;

   // The front end owns the command store, its head index and entry count.
   // It classifies each request as an enqueue, an ACK, a resend, a scancode
   // or something to drop, and emits at most one job per request.
   phcq_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .jobq_full (jobq_full),
      .push      (push),
      .push_job  (push_job)
   );

   phcq_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (jobq_full),
      .valid    (jobq_valid),
      .head_job (jobq_head)
   );

   // The output sequencer sends the high byte of a command first when it is
   // nonzero, then the low byte, and flags the final response transaction of
   // each job with last.
   phcq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (jobq_valid),
      .job       (jobq_head),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule
